// ----- sv/kea_pkg.sv -----
// Shared types, number-format constants and the arctangent table for the Kepler solver.
// No dependencies; every other file refers to this package by scoped names.
package kea_pkg;

  localparam int FRACTION_BITS  = 60;
  localparam int MAX_ITERATIONS = 16;
  localparam int CORDIC_STEPS   = 62;
  localparam int LIMIT_W        = 41;
  localparam int ECC_W          = 61;
  localparam int CFG_IDX_W      = 1;
  localparam int IT_W           = $clog2(MAX_ITERATIONS + 1);
  localparam int STEP_W         = $clog2(CORDIC_STEPS);
  localparam int DIV_W          = 64 + FRACTION_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_W);

  localparam logic [CFG_IDX_W-1:0] REG_CORR_LIMIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RESID_LIMIT = CFG_IDX_W'(1);

  localparam logic [LIMIT_W-1:0] CORR_LIMIT_RST  = LIMIT_W'(115292);
  localparam logic [LIMIT_W-1:0] RESID_LIMIT_RST = LIMIT_W'(1152922);

  localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;
  localparam logic signed [63:0] GAIN_Q62 = 64'sd2800459870029452954;

  localparam logic signed [63:0] ONE_F = 64'sd1 <<< FRACTION_BITS;
  localparam logic signed [63:0] PI_F =
    $signed((PI_Q62 + (64'd1 << (61 - FRACTION_BITS))) >> (62 - FRACTION_BITS));
  localparam logic signed [63:0] TWO_PI_F  = PI_F <<< 1;
  localparam logic signed [63:0] HALF_PI_F = PI_F >>> 1;
  localparam logic [63:0] ECC_08_F = ((64'd1 << (FRACTION_BITS + 2)) + 64'd2) / 64'd5;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_ECC  = 3'd1,
    ST_DEN      = 3'd2,
    ST_RESID    = 3'd3,
    ST_NO_CONV  = 3'd4
  } status_e;

  typedef logic signed [63:0] atan_tab_t [CORDIC_STEPS];

  // arctan(2^-i) in Q1.62 from the alternating power series
  function automatic atan_tab_t build_atan();
    atan_tab_t t;
    logic signed [63:0] sum;
    logic [63:0] term;
    int sh;
    t[0] = $signed(PI_Q62 >> 2);
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      sum = '0;
      for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
        sh   = 62 - i * (2 * k + 1);
        term = (64'd1 << sh) / 64'(2 * k + 1);
        sum  = (k % 2 == 1) ? sum - $signed(term) : sum + $signed(term);
      end
      t[i] = sum;
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN = build_atan();

  // true when a 66-bit signed value fits in 64 bits
  function automatic logic fits64(input logic signed [65:0] v);
    return (v[65:63] == 3'b000) || (v[65:63] == 3'b111);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

// ----- sv/kea_cordic.sv -----
// Iterative rotation-mode CORDIC: sine and cosine in Q1.62 of a Q3.60 angle.
// Depends on kea_pkg (format constants, arctangent table).
module kea_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] angle_i,
  output logic               done_o,
  output logic signed [63:0] sin_o,
  output logic signed [63:0] cos_o
);

  localparam int STEP_W_L = kea_pkg::STEP_W;

  typedef enum logic [2:0] {C_IDLE, C_MOD, C_WRAP, C_FOLD, C_ROT, C_FIN} cstate_e;

  cstate_e state_q;
  logic [63:0] rem_q;
  logic neg_q, flip_q, done_q;
  logic signed [63:0] r_q, x_q, y_q, z_q, sin_q, cos_q;
  logic [STEP_W_L-1:0] i_q;

  logic signed [63:0] ysh, xsh, x_n, y_n, z_n, rf;
  logic fold_hi, fold_lo;

  always_comb begin
    ysh = y_q >>> i_q;
    xsh = x_q >>> i_q;
    if (!z_q[63]) begin
      x_n = x_q - ysh;
      y_n = y_q + xsh;
      z_n = z_q - kea_pkg::ATAN[i_q];
    end else begin
      x_n = x_q + ysh;
      y_n = y_q - xsh;
      z_n = z_q + kea_pkg::ATAN[i_q];
    end
    fold_hi = r_q > kea_pkg::HALF_PI_F;
    fold_lo = r_q < -kea_pkg::HALF_PI_F;
    if (fold_hi)      rf = r_q - kea_pkg::PI_F;
    else if (fold_lo) rf = r_q + kea_pkg::PI_F;
    else              rf = r_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            rem_q   <= kea_pkg::mag64(angle_i);
            neg_q   <= angle_i[63];
            state_q <= C_MOD;
          end
        end
        C_MOD: begin
          if (rem_q >= 64'(kea_pkg::TWO_PI_F)) begin
            rem_q <= rem_q - 64'(kea_pkg::TWO_PI_F);
          end else begin
            r_q     <= neg_q ? -$signed(rem_q) : $signed(rem_q);
            state_q <= C_WRAP;
          end
        end
        C_WRAP: begin
          if (r_q > kea_pkg::PI_F)       r_q <= r_q - kea_pkg::TWO_PI_F;
          else if (r_q < -kea_pkg::PI_F) r_q <= r_q + kea_pkg::TWO_PI_F;
          state_q <= C_FOLD;
        end
        C_FOLD: begin
          flip_q  <= fold_hi || fold_lo;
          z_q     <= rf <<< (62 - kea_pkg::FRACTION_BITS);
          x_q     <= kea_pkg::GAIN_Q62;
          y_q     <= '0;
          i_q     <= '0;
          state_q <= C_ROT;
        end
        C_ROT: begin
          x_q <= x_n;
          y_q <= y_n;
          z_q <= z_n;
          i_q <= i_q + 1'b1;
          if (i_q == STEP_W_L'(kea_pkg::CORDIC_STEPS - 1)) state_q <= C_FIN;
        end
        C_FIN: begin
          sin_q   <= flip_q ? -y_q : y_q;
          cos_q   <= flip_q ? -x_q : x_q;
          done_q  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

// ----- sv/kea_mul.sv -----
// Sequential e * s multiplier: four 32x32 partial products, result shifted right by 62.
// Depends on kea_pkg (widths, magnitude helper).
module kea_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [kea_pkg::ECC_W-1:0]      a_i,
  input  logic signed [63:0]             s_i,
  output logic                           done_o,
  output logic signed [63:0]             p_o
);

  logic [63:0] a_q, b_q, pp_q;
  logic [127:0] acc_q, pp_w;
  logic [1:0] wt_q;
  logic [2:0] cnt_q;
  logic neg_q, busy_q, done_q;
  logic [31:0] ah, bh;
  logic [63:0] r;

  always_comb begin
    ah = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    bh = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    case (wt_q)
      2'd0:    pp_w = {64'd0, pp_q};
      2'd1:    pp_w = {32'd0, pp_q, 32'd0};
      default: pp_w = {pp_q, 64'd0};
    endcase
    r = acc_q[125:62];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q    <= 64'(a_i);
        b_q    <= kea_pkg::mag64(s_i);
        neg_q  <= s_i[63];
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (cnt_q != 3'd4) begin
          pp_q <= ah * bh;
          wt_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
        end
        if (cnt_q != 3'd0) acc_q <= acc_q + pp_w;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = neg_q ? -$signed(r) : $signed(r);

endmodule

// ----- sv/kea_div.sv -----
// Restoring divider: num * 2^F / den, one quotient bit per cycle, with overflow flag.
// Depends on kea_pkg (widths, magnitude helper).
module kea_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic               done_o,
  output logic               ovf_o,
  output logic signed [63:0] quo_o
);

  localparam int W  = kea_pkg::DIV_W;
  localparam int CW = kea_pkg::DIV_CNT_W;

  logic [W-1:0] dvd_q, q_q;
  logic [63:0] rem_q, d_q;
  logic [CW-1:0] cnt_q;
  logic neg_q, busy_q, done_q;
  logic [64:0] rem_sh, rem_sub;
  logic ge;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[W-1]};
    rem_sub = rem_sh - {1'b0, d_q};
    ge      = rem_sh >= {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q  <= W'(kea_pkg::mag64(num_i)) << kea_pkg::FRACTION_BITS;
        d_q    <= 64'(den_i);
        neg_q  <= num_i[63];
        q_q    <= '0;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? rem_sub[63:0] : rem_sh[63:0];
        q_q   <= {q_q[W-2:0], ge};
        dvd_q <= dvd_q << 1;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign ovf_o  = |q_q[W-1:63];
  assign quo_o  = neg_q ? -$signed(q_q[63:0]) : $signed(q_q[63:0]);

endmodule

// ----- sv/kepler_eccentric_anomaly_solver.sv -----
// Top level of the Kepler solver: sequencer, limit registers and output register.
// Depends on kea_pkg, kea_cordic, kea_mul and kea_div.
//
// Solves E - e sin E = M by Newton iteration in Q3.60 fixed point. One item is in
// flight at a time: in_stall_o stays high from the accepted transfer until the result
// transfer completes. Each Newton step runs the CORDIC (62 rotations, after reducing
// the angle when needed), the 4-product multiplier twice and the bit-serial divider
// (124 quotient bits), plus the S_NUM and S_UPD sequencing states. The final residual
// check runs a further CORDIC and multiply. An item takes at most 16 Newton steps; a bad
// eccentricity is answered the cycle after its transfer. The user must write the
// limits through cfg_we_i/cfg_idx_i/cfg_data_i only while idle; the block itself does
// not enforce this. Index 0 is the correction limit, index 1 the residual limit.
module kepler_eccentric_anomaly_solver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kea_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [kea_pkg::LIMIT_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [63:0]                mean_anomaly_i,
  input  logic [kea_pkg::ECC_W-1:0]         eccentricity_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [63:0]                eccentric_anomaly_o,
  output logic [2:0]                        status_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_INIT, S_SC, S_MC, S_MS, S_NUM, S_DIV, S_UPD,
    S_RSC, S_RMS, S_RES, S_OUT
  } state_e;

  state_e state_q;
  logic [kea_pkg::LIMIT_W-1:0] corr_lim_q, resid_lim_q;
  logic signed [63:0] m_q, ea_q, sn_q, cs_q, es_q, den_q, num_q, corr_q;
  logic [kea_pkg::ECC_W-1:0] e_q;
  logic [kea_pkg::IT_W-1:0] it_q;
  logic cs_start_q, mul_start_q, div_start_q;
  logic out_valid_q;
  logic signed [63:0] out_ea_q;
  logic [2:0] out_status_q;

  // shared units
  logic cs_done, mul_done, div_done, div_ovf;
  logic signed [63:0] sin_w, cos_w, mul_p, div_q, mul_s;

  assign mul_s = (state_q == S_MC) ? cs_q : sn_q;

  kea_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cs_start_q),
    .angle_i (ea_q),
    .done_o  (cs_done),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  kea_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (e_q),
    .s_i     (mul_s),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  kea_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .ovf_o   (div_ovf),
    .quo_o   (div_q)
  );

  // ea - e*sin - m with the two range checks; shared by the step and the residual
  logic signed [65:0] t1, t2, eu;
  logic diff_ovf, upd_ovf, den_bad, conv, res_bad;
  logic signed [63:0] den_w;

  always_comb begin
    t1       = {{2{ea_q[63]}}, ea_q} - {{2{es_q[63]}}, es_q};
    t2       = t1 - {{2{m_q[63]}}, m_q};
    diff_ovf = !kea_pkg::fits64(t1) || !kea_pkg::fits64(t2);
    eu       = {{2{ea_q[63]}}, ea_q} - {{2{corr_q[63]}}, corr_q};
    upd_ovf  = !kea_pkg::fits64(eu);
    den_w    = kea_pkg::ONE_F - mul_p;
    den_bad  = (den_w <= 64'sd0);
    conv     = kea_pkg::mag64(corr_q) < 64'(corr_lim_q);
    res_bad  = diff_ovf || (kea_pkg::mag64(t2[63:0]) > 64'(resid_lim_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_lim_q  <= kea_pkg::CORR_LIMIT_RST;
      resid_lim_q <= kea_pkg::RESID_LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == kea_pkg::REG_CORR_LIMIT)  corr_lim_q  <= cfg_data_i;
      if (cfg_idx_i == kea_pkg::REG_RESID_LIMIT) resid_lim_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cs_start_q  <= 1'b0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      cs_start_q  <= 1'b0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            m_q <= mean_anomaly_i;
            e_q <= eccentricity_i;
            if (64'(eccentricity_i) >= 64'(kea_pkg::ONE_F)) begin
              out_ea_q     <= '0;
              out_status_q <= kea_pkg::ST_BAD_ECC;
              out_valid_q  <= 1'b1;
              state_q      <= S_OUT;
            end else begin
              state_q <= S_WRAP;
            end
          end
        end
        S_WRAP: begin
          // single 2*pi wrap of M
          if (m_q > kea_pkg::PI_F)       m_q <= m_q - kea_pkg::TWO_PI_F;
          else if (m_q < -kea_pkg::PI_F) m_q <= m_q + kea_pkg::TWO_PI_F;
          state_q <= S_INIT;
        end
        S_INIT: begin
          if (64'(e_q) < kea_pkg::ECC_08_F) ea_q <= m_q;
          else ea_q <= m_q[63] ? -kea_pkg::PI_F : kea_pkg::PI_F;
          it_q       <= '0;
          cs_start_q <= 1'b1;
          state_q    <= S_SC;
        end
        S_SC: begin
          if (cs_done) begin
            sn_q        <= sin_w;
            cs_q        <= cos_w;
            mul_start_q <= 1'b1;
            state_q     <= S_MC;
          end
        end
        S_MC: begin
          if (mul_done) begin
            den_q <= den_w;
            if (den_bad) begin
              out_ea_q     <= '0;
              out_status_q <= kea_pkg::ST_DEN;
              out_valid_q  <= 1'b1;
              state_q      <= S_OUT;
            end else begin
              mul_start_q <= 1'b1;
              state_q     <= S_MS;
            end
          end
        end
        S_MS: begin
          if (mul_done) begin
            es_q    <= mul_p;
            state_q <= S_NUM;
          end
        end
        S_NUM: begin
          if (diff_ovf) begin
            out_ea_q     <= '0;
            out_status_q <= kea_pkg::ST_NO_CONV;
            out_valid_q  <= 1'b1;
            state_q      <= S_OUT;
          end else begin
            num_q       <= t2[63:0];
            div_start_q <= 1'b1;
            state_q     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_ovf) begin
              out_ea_q     <= '0;
              out_status_q <= kea_pkg::ST_NO_CONV;
              out_valid_q  <= 1'b1;
              state_q      <= S_OUT;
            end else begin
              corr_q  <= div_q;
              state_q <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (upd_ovf) begin
            out_ea_q     <= '0;
            out_status_q <= kea_pkg::ST_NO_CONV;
            out_valid_q  <= 1'b1;
            state_q      <= S_OUT;
          end else begin
            ea_q <= eu[63:0];
            if (conv) begin
              cs_start_q <= 1'b1;
              state_q    <= S_RSC;
            end else if (it_q == kea_pkg::IT_W'(kea_pkg::MAX_ITERATIONS - 1)) begin
              out_ea_q     <= '0;
              out_status_q <= kea_pkg::ST_NO_CONV;
              out_valid_q  <= 1'b1;
              state_q      <= S_OUT;
            end else begin
              it_q       <= it_q + 1'b1;
              cs_start_q <= 1'b1;
              state_q    <= S_SC;
            end
          end
        end
        S_RSC: begin
          if (cs_done) begin
            sn_q        <= sin_w;
            mul_start_q <= 1'b1;
            state_q     <= S_RMS;
          end
        end
        S_RMS: begin
          if (mul_done) begin
            es_q    <= mul_p;
            state_q <= S_RES;
          end
        end
        S_RES: begin
          if (res_bad) begin
            out_ea_q     <= '0;
            out_status_q <= kea_pkg::ST_RESID;
          end else begin
            out_ea_q     <= ea_q;
            out_status_q <= kea_pkg::ST_OK;
          end
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o          = (state_q != S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign eccentric_anomaly_o = out_ea_q;
  assign status_o            = out_status_q;

endmodule
